>>> design/slpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the spectral projection / dealiasing core.
// No dependencies; imported by the top level, slpd_checker and tb_top.
package slpd_pkg;

    localparam int VEL_W     = 32;
    localparam int N_PART    = 6;
    localparam int GRID_W    = 9;
    localparam int IDX_W     = 8;
    localparam int DIV_BPS   = 4;
    localparam logic [GRID_W-1:0] GRID_RESET = 9'd24;
    // floor(n / 3) == (n * RECIP3) >> RECIP3_SH for every 9-bit n
    localparam int RECIP3    = 171;
    localparam int RECIP3_SH = 9;
    localparam int VEL_MAX   = 32'h7FFF_FFFF;
    localparam int VEL_MIN   = 32'sh8000_0000;

    typedef logic signed [VEL_W-1:0] t_vel;

    // sideband that travels beside the divider lanes
    typedef struct packed {
        logic              zeroed;
        logic              pass;
        logic [N_PART-1:0] neg;
        t_vel [N_PART-1:0] u;
    } t_side;

endpackage

>>> design/slpd_div.sv
`timescale 1ns / 1ps
// Pipelined restoring unsigned divider, BPS quotient bits per stage.
// Uses no package; instantiated by spectral_leray_projection_dealias_core.
module slpd_div #(
    parameter int NUMW = 50,
    parameter int DENW = 16,
    parameter int BPS  = 4
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [NUMW-1:0] i_num,
    input  logic [DENW-1:0] i_den,
    output logic [NUMW-1:0] o_quo
);
    localparam int STG  = (NUMW + BPS - 1) / BPS;
    localparam int NPAD = STG * BPS;

    logic [DENW-1:0] r_rem [STG];
    logic [NPAD-1:0] r_nq  [STG];
    logic [DENW-1:0] r_den [STG];

    for (genvar s = 0; s < STG; s++) begin : g_stg
        logic [DENW-1:0] a_rem;
        logic [DENW-1:0] a_den;
        logic [NPAD-1:0] a_nq;
        logic [DENW:0]   t;
        logic [DENW-1:0] n_rem;
        logic [NPAD-1:0] n_nq;

        if (s == 0) begin : g_in
            assign a_rem = '0;
            assign a_nq  = NPAD'(i_num);
            assign a_den = i_den;
        end else begin : g_mid
            assign a_rem = r_rem[s-1];
            assign a_nq  = r_nq[s-1];
            assign a_den = r_den[s-1];
        end

        // shift one numerator bit in, subtract when it fits
        always_comb begin
            n_rem = a_rem;
            n_nq  = a_nq;
            t     = '0;
            for (int b = 0; b < BPS; b++) begin
                t    = {n_rem, n_nq[NPAD-1]};
                n_nq = {n_nq[NPAD-2:0], 1'b0};
                if (t >= {1'b0, a_den}) begin
                    t       = t - {1'b0, a_den};
                    n_nq[0] = 1'b1;
                end
                n_rem = t[DENW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_nq[s]  <= n_nq;
                r_den[s] <= a_den;
            end
        end
    end

    assign o_quo = r_nq[STG-1][NUMW-1:0];

endmodule

>>> design/spectral_leray_projection_dealias_core.sv
`timescale 1ns / 1ps
// Leray projection with two-thirds dealiasing, one spectral mode per transaction.
// Pipeline: stages A to D, six divider lanes (4 bits a stage), output register.
// Throughput: one transaction per cycle while the output is not stalled.
// A stall at the output freezes the whole pipe; nothing is dropped or repeated.
// Reset (synchronous, active low): grid size returns to 24, all valid bits clear.
// Depends on slpd_pkg and slpd_div.
module spectral_leray_projection_dealias_core #(
    parameter int MAX_GRID = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [slpd_pkg::GRID_W-1:0] i_cfg_wdata,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [slpd_pkg::IDX_W-1:0]  i_idx_x,
    input  logic [slpd_pkg::IDX_W-1:0]  i_idx_y,
    input  logic [slpd_pkg::IDX_W-1:0]  i_idx_z,
    input  slpd_pkg::t_vel              i_vel_x_re,
    input  slpd_pkg::t_vel              i_vel_x_im,
    input  slpd_pkg::t_vel              i_vel_y_re,
    input  slpd_pkg::t_vel              i_vel_y_im,
    input  slpd_pkg::t_vel              i_vel_z_re,
    input  slpd_pkg::t_vel              i_vel_z_im,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output slpd_pkg::t_vel              o_out_x_re,
    output slpd_pkg::t_vel              o_out_x_im,
    output slpd_pkg::t_vel              o_out_y_re,
    output slpd_pkg::t_vel              o_out_y_im,
    output slpd_pkg::t_vel              o_out_z_re,
    output slpd_pkg::t_vel              o_out_z_im,
    output logic                        o_was_zeroed
);
    import slpd_pkg::*;

    // widths that follow from the largest cutoff
    localparam int CUT_MAX = MAX_GRID / 3;
    localparam int KMW     = $clog2(CUT_MAX + 1);     // |k| magnitude bits
    localparam int KW      = KMW + 1;                 // signed wave number
    localparam int PW      = VEL_W + KW;              // k * u
    localparam int DW      = PW + 2;                  // sum of three products
    localparam int NW      = DW + KW;                 // k * d
    localparam int K2W     = 2 * KMW + 2;             // |k|^2
    localparam int DS      = (NW + DIV_BPS - 1) / DIV_BPS;

    localparam logic signed [NW+1:0] SAT_HI = (NW+2)'(VEL_MAX);
    localparam logic signed [NW+1:0] SAT_LO = (NW+2)'(VEL_MIN);

    // ---------------------------------------------------------------
    // Configuration: keep grid size, half and cutoff precomputed
    // ---------------------------------------------------------------
    logic [GRID_W-1:0]           r_grid;
    logic [IDX_W-1:0]            r_half;
    logic [KMW-1:0]              r_cutoff;
    logic [GRID_W-1:0]           n_grid;
    logic [GRID_W+IDX_W-1:0]     cut_prod;

    always_comb begin
        n_grid = i_cfg_wdata;
        if (32'(i_cfg_wdata) > MAX_GRID) begin
            n_grid = GRID_W'(MAX_GRID);
        end
        cut_prod = (GRID_W+IDX_W)'(n_grid) * (GRID_W+IDX_W)'(RECIP3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid   <= GRID_RESET;
            r_half   <= IDX_W'(GRID_RESET >> 1);
            r_cutoff <= KMW'(GRID_RESET / 3);
        end else if (i_cfg_we) begin
            r_grid   <= n_grid;
            r_half   <= n_grid[GRID_W-1:1];
            r_cutoff <= KMW'(cut_prod >> RECIP3_SH);
        end
    end

    // ---------------------------------------------------------------
    // Flow control: the pipe moves as one unless the output holds a
    // transaction that the sink stalls
    // ---------------------------------------------------------------
    logic adv;
    logic r_out_valid;

    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_out_valid;

    // ---------------------------------------------------------------
    // Stage A: wave numbers and the cutoff test
    // ---------------------------------------------------------------
    logic [IDX_W-1:0]        idx_in [3];
    logic signed [GRID_W+1:0] kw    [3];
    logic [GRID_W+1:0]       km     [3];
    logic                    n_cut;
    t_vel [N_PART-1:0]       u_in;

    assign idx_in[0] = i_idx_x;
    assign idx_in[1] = i_idx_y;
    assign idx_in[2] = i_idx_z;
    assign u_in = {i_vel_z_im, i_vel_z_re, i_vel_y_im, i_vel_y_re, i_vel_x_im, i_vel_x_re};

    always_comb begin
        n_cut = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (idx_in[a] <= r_half) begin
                kw[a] = $signed({3'b0, idx_in[a]});
            end else begin
                kw[a] = $signed({3'b0, idx_in[a]}) - $signed({2'b0, r_grid});
            end
            km[a] = kw[a][GRID_W+1] ? (GRID_W+2)'(-kw[a]) : kw[a];
            if (km[a] > (GRID_W+2)'(r_cutoff)) begin
                n_cut = 1'b1;
            end
        end
    end

    logic                    rA_valid;
    logic                    rA_zero;
    logic signed [KW-1:0]    rA_k [3];
    t_vel [N_PART-1:0]       rA_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_valid <= 1'b0;
        end else if (adv) begin
            rA_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rA_zero <= n_cut;
            for (int a = 0; a < 3; a++) begin
                rA_k[a] <= KW'(kw[a]);
            end
            rA_u <= u_in;
        end
    end

    // ---------------------------------------------------------------
    // Stage B: |k|^2 and the six k*u products
    // ---------------------------------------------------------------
    logic signed [K2W:0]     k2_sum;
    logic                    rB_valid;
    logic                    rB_zero;
    logic signed [KW-1:0]    rB_k [3];
    logic [K2W-1:0]          rB_k2;
    logic signed [PW-1:0]    rB_p [N_PART];
    t_vel [N_PART-1:0]       rB_u;

    assign k2_sum = (K2W+1)'(rA_k[0]) * (K2W+1)'(rA_k[0])
                  + (K2W+1)'(rA_k[1]) * (K2W+1)'(rA_k[1])
                  + (K2W+1)'(rA_k[2]) * (K2W+1)'(rA_k[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rB_valid <= 1'b0;
        end else if (adv) begin
            rB_valid <= rA_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rB_zero <= rA_zero;
            rB_k    <= rA_k;
            rB_k2   <= k2_sum[K2W-1:0];
            rB_u    <= rA_u;
            for (int j = 0; j < N_PART; j++) begin
                rB_p[j] <= PW'(rA_k[j/2]) * PW'(rA_u[j]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage C: dot products for the real and imaginary parts
    // ---------------------------------------------------------------
    logic                    rC_valid;
    logic                    rC_zero;
    logic signed [KW-1:0]    rC_k [3];
    logic [K2W-1:0]          rC_k2;
    logic signed [DW-1:0]    rC_d [2];
    t_vel [N_PART-1:0]       rC_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rC_valid <= 1'b0;
        end else if (adv) begin
            rC_valid <= rB_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rC_zero <= rB_zero;
            rC_k    <= rB_k;
            rC_k2   <= rB_k2;
            rC_u    <= rB_u;
            for (int p = 0; p < 2; p++) begin
                rC_d[p] <= DW'(rB_p[p]) + DW'(rB_p[2+p]) + DW'(rB_p[4+p]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage D: numerators k_c * d
    // ---------------------------------------------------------------
    logic                    rD_valid;
    logic                    rD_zero;
    logic [K2W-1:0]          rD_k2;
    logic signed [NW-1:0]    rD_num [N_PART];
    t_vel [N_PART-1:0]       rD_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rD_valid <= 1'b0;
        end else if (adv) begin
            rD_valid <= rC_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rD_zero <= rC_zero;
            rD_k2   <= rC_k2;
            rD_u    <= rC_u;
            for (int j = 0; j < N_PART; j++) begin
                rD_num[j] <= NW'(rC_k[j/2]) * NW'(rC_d[j%2]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Divider lanes: |k_c * d| / |k|^2, sideband rides alongside
    // ---------------------------------------------------------------
    logic [NW-1:0]           num_mag [N_PART];
    logic [NW-1:0]           quo     [N_PART];
    t_side                   side_in;
    t_side                   r_side  [DS];
    logic [DS-1:0]           r_dv;

    always_comb begin
        side_in.zeroed = rD_zero;
        side_in.pass   = (rD_k2 == '0);
        side_in.u      = rD_u;
        for (int j = 0; j < N_PART; j++) begin
            side_in.neg[j] = rD_num[j][NW-1];
            num_mag[j]     = rD_num[j][NW-1] ? NW'(-rD_num[j]) : NW'(rD_num[j]);
        end
    end

    for (genvar j = 0; j < N_PART; j++) begin : g_lane
        slpd_div #(
            .NUMW (NW),
            .DENW (K2W),
            .BPS  (DIV_BPS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (num_mag[j]),
            .i_den (rD_k2),
            .o_quo (quo[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (adv) begin
            r_dv <= {r_dv[DS-2:0], rD_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= side_in;
            for (int s = 1; s < DS; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Final stage: apply sign, subtract, saturate, pick the case
    // ---------------------------------------------------------------
    t_side                   sd;
    logic signed [NW:0]      corr [N_PART];
    logic signed [NW+1:0]    diff [N_PART];
    t_vel [N_PART-1:0]       n_out;

    assign sd = r_side[DS-1];

    always_comb begin
        for (int j = 0; j < N_PART; j++) begin
            corr[j] = sd.neg[j] ? -$signed({1'b0, quo[j]}) : $signed({1'b0, quo[j]});
            diff[j] = (NW+2)'(sd.u[j]) - (NW+2)'(corr[j]);
            priority if (sd.zeroed) begin
                n_out[j] = '0;
            end else if (sd.pass) begin
                n_out[j] = sd.u[j];
            end else if (diff[j] > SAT_HI) begin
                n_out[j] = VEL_W'(VEL_MAX);
            end else if (diff[j] < SAT_LO) begin
                n_out[j] = VEL_W'(VEL_MIN);
            end else begin
                n_out[j] = VEL_W'(diff[j]);
            end
        end
    end

    t_vel [N_PART-1:0]       r_out;
    logic                    r_out_zeroed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_dv[DS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out        <= n_out;
            r_out_zeroed <= sd.zeroed;
        end
    end

    assign o_out_x_re   = r_out[0];
    assign o_out_x_im   = r_out[1];
    assign o_out_y_re   = r_out[2];
    assign o_out_y_im   = r_out[3];
    assign o_out_z_re   = r_out[4];
    assign o_out_z_im   = r_out[5];
    assign o_was_zeroed = r_out_zeroed;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_zeroed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_was_zeroed) |-> (r_out == '0))
        else $error("cleared mode carries nonzero velocity");

    a_grid_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_grid) <= MAX_GRID)
        else $error("grid size above cap");

    a_cutoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cutoff) * 3 <= 32'(r_grid)) && (32'(r_grid) <= 32'(r_cutoff) * 3 + 2))
        else $error("cutoff register out of step with grid size");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_dv) && $stable(r_out_valid)))
        else $error("pipeline moved while output stalled");

endmodule

>>> tb/sv/slpd_checker.sv
`timescale 1ns / 1ps
// Checker for the spectral projection / dealiasing core: predicts each result
// from accepted input transactions and compares. Depends on slpd_pkg.
module slpd_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [slpd_pkg::GRID_W-1:0] i_cfg_wdata,
    input  logic                        i_valid,
    input  logic                        i_in_stall,
    input  logic [slpd_pkg::IDX_W-1:0]  i_idx_x,
    input  logic [slpd_pkg::IDX_W-1:0]  i_idx_y,
    input  logic [slpd_pkg::IDX_W-1:0]  i_idx_z,
    input  slpd_pkg::t_vel              i_vel [6],
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  slpd_pkg::t_vel              i_res [6],
    input  logic                        i_res_zeroed,
    output int                          o_fail_count,
    output int                          o_pending
);
    import slpd_pkg::*;

    typedef struct {
        t_vel v [6];
        logic zeroed;
    } t_mode_res;

    t_mode_res  projected_q[$];
    int         grid_n;
    int         fails;

    assign o_fail_count = fails;
    assign o_pending    = projected_q.size();

    function automatic longint fold_index(logic [7:0] q, longint n);
        longint qi;
        qi = q;
        return (qi <= n / 2) ? qi : qi - n;
    endfunction

    function automatic t_vel clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return t_vel'(v);
    endfunction

    function automatic t_mode_res project_mode(logic [7:0] qx, logic [7:0] qy,
                                               logic [7:0] qz, t_vel u [6]);
        t_mode_res r;
        longint    k [3];
        longint    n, cut, k2, d, corr;
        n      = grid_n;
        cut    = n / 3;
        k[0]   = fold_index(qx, n);
        k[1]   = fold_index(qy, n);
        k[2]   = fold_index(qz, n);
        r.zeroed = 1'b0;
        if ((k[0] < 0 ? -k[0] : k[0]) > cut || (k[1] < 0 ? -k[1] : k[1]) > cut ||
            (k[2] < 0 ? -k[2] : k[2]) > cut) begin
            foreach (r.v[i]) r.v[i] = '0;
            r.zeroed = 1'b1;
            return r;
        end
        k2 = k[0] * k[0] + k[1] * k[1] + k[2] * k[2];
        for (int p = 0; p < 2; p++) begin
            d = k[0] * longint'(u[p]) + k[1] * longint'(u[2 + p])
                + k[2] * longint'(u[4 + p]);
            for (int c = 0; c < 3; c++) begin
                corr = (k2 == 0) ? 0 : (k[c] * d) / k2;
                r.v[2 * c + p] = clamp32(longint'(u[2 * c + p]) - corr);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_mode_res want;
        if (!i_rst_n) begin
            grid_n <= GRID_RESET;
            fails  <= 0;
        end else begin
            if (i_cfg_we) grid_n <= (i_cfg_wdata > 256) ? 256 : i_cfg_wdata;
            if (i_valid && !i_in_stall)
                projected_q.push_back(project_mode(i_idx_x, i_idx_y, i_idx_z, i_vel));
            if (i_out_valid && !i_out_stall) begin
                if (projected_q.size() == 0) begin
                    $display("MISMATCH unexpected result at %0t", $time);
                    fails++;
                end else begin
                    want = projected_q.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (i_res[i] !== want.v[i])
                            report_mismatch($sformatf("part %0d", i), i_res[i], want.v[i]);
                    if (i_res_zeroed !== want.zeroed)
                        report_mismatch("was_zeroed", i_res_zeroed, want.zeroed);
                end
            end
        end
    end
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the testbench for spectral_leray_projection_dealias_core: clock, reset,
// stimulus, stall patterns and verdict. Depends on slpd_pkg and slpd_checker.
module tb_top;
    import slpd_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG     = 20000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [GRID_W-1:0] cfg_wdata;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        idx_x, idx_y, idx_z;
    t_vel              vel [6];
    logic              out_valid;
    logic              out_stall;
    t_vel              res [6];
    logic              res_zeroed;
    int                fail_count;
    int                pending;
    bit                calm;       // no idling in the final stretch
    bit                hold_rx;    // long receiver hold-off request
    int                idle_cycles;

    spectral_leray_projection_dealias_core DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_idx_x(idx_x), .i_idx_y(idx_y), .i_idx_z(idx_z),
        .i_vel_x_re(vel[0]), .i_vel_x_im(vel[1]), .i_vel_y_re(vel[2]),
        .i_vel_y_im(vel[3]), .i_vel_z_re(vel[4]), .i_vel_z_im(vel[5]),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_out_x_re(res[0]), .o_out_x_im(res[1]), .o_out_y_re(res[2]),
        .o_out_y_im(res[3]), .o_out_z_re(res[4]), .o_out_z_im(res[5]),
        .o_was_zeroed(res_zeroed)
    );

    slpd_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .i_in_stall(in_stall),
        .i_idx_x(idx_x), .i_idx_y(idx_y), .i_idx_z(idx_z), .i_vel(vel),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_res(res),
        .i_res_zeroed(res_zeroed), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: count cycles with no accepted transaction on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("spectral_leray_projection_dealias_core verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, a long hold-off on request, none when calm.
    initial begin
        int n;
        out_stall = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_rx) begin
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk iff !hold_rx);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 15);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // Offer one mode and hold it until accepted; a random idle gap first when asked.
    task automatic send_mode(logic [7:0] qx, logic [7:0] qy, logic [7:0] qz,
                             t_vel u [6], bit gaps);
        int n;
        if (gaps && !calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        idx_x    <= qx;
        idx_y    <= qy;
        idx_z    <= qz;
        for (int i = 0; i < 6; i++) vel[i] <= u[i];
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid, wait until every expected result is back, then let the pipe drain.
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_grid(logic [GRID_W-1:0] n);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic t_vel rand_vel();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return t_vel'($urandom_range(0, 8)) - 4;
            default: return t_vel'($urandom);
        endcase
    endfunction

    // Index close to the cutoff band for grid n, occasionally anything.
    function automatic logic [7:0] rand_idx(int n);
        int c;
        c = n / 3;
        if ($urandom_range(0, 9) == 0 || n == 0) return 8'($urandom);
        if ($urandom_range(0, 1)) return 8'($urandom_range(0, c + 1));
        return 8'((n - $urandom_range(0, c + 1)) % 256);
    endfunction

    initial begin
        t_vel u [6];
        int   grids [8];
        int   g;
        grids     = '{24, 256, 8, 0, 9, 511, 100, 66};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        idx_x     = '0;
        idx_y     = '0;
        idx_z     = '0;
        calm      = 1'b0;
        hold_rx   = 1'b0;
        for (int i = 0; i < 6; i++) vel[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero mode, extremes, cutoff edges and saturation at reset grid.
        foreach (u[i]) u[i] = 32'sh7FFF_FFFF;
        send_mode(0, 0, 0, u, 0);
        send_mode(8, 0, 0, u, 0);
        send_mode(9, 0, 0, u, 0);
        send_mode(16, 16, 16, u, 0);
        send_mode(15, 0, 0, u, 0);
        send_mode(255, 255, 255, u, 0);
        foreach (u[i]) u[i] = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        send_mode(1, 1, 1, u, 0);
        send_mode(8, 16, 8, u, 0);
        send_mode(0, 0, 0, u, 0);
        foreach (u[i]) u[i] = 32'sh8000_0000;
        send_mode(1, 23, 0, u, 0);
        send_mode(0, 0, 1, u, 0);
        send_mode(12, 12, 12, u, 0);
        for (int j = 0; j < 8; j++) begin
            foreach (u[i]) u[i] = rand_vel();
            send_mode(8'hAA ^ 8'(j), 8'h55, 8'(j), u, 0);
        end
        drain_pipe();

        // Random phases across grid settings, extremes included.
        for (int ph = 0; ph < 8; ph++) begin
            g = grids[ph];
            write_grid(GRID_W'(g));
            if (g > 256) g = 256;
            if (ph == 2) hold_rx = 1'b1;   // back up the pipe so the input stalls
            if (ph == 7) calm = 1'b1;
            for (int j = 0; j < 85; j++) begin
                if (ph == 2 && j == 60) hold_rx = 1'b0;
                foreach (u[i]) u[i] = rand_vel();
                send_mode(rand_idx(g), rand_idx(g), rand_idx(g), u, 1);
                if (ph == 4 && j == 40) drain_pipe();   // sender waits out every result
            end
            drain_pipe();
        end

        if (fail_count == 0)
            $display("spectral_leray_projection_dealias_core verification clean");
        else
            $display("spectral_leray_projection_dealias_core verification failed");
        $finish;
    end
endmodule
